@@ hw/rtl/ort_pkg.sv @@
// shared types and codes of the outstanding request tracker
// no dependencies
`timescale 1ns / 1ps
package ort_pkg;

  localparam logic [1:0] ACT_SEND  = 2'd0;
  localparam logic [1:0] ACT_MSG   = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;
  localparam logic [1:0] ACT_CLOSE = 2'd3;

  localparam logic [2:0] KIND_SENT    = 3'd0;
  localparam logic [2:0] KIND_REPLY   = 3'd1;
  localparam logic [2:0] KIND_FAILED  = 3'd2;
  localparam logic [2:0] KIND_FWD     = 3'd3;
  localparam logic [2:0] KIND_CLOSED  = 3'd4;

  localparam logic [2:0] RSN_NONE    = 3'd0;
  localparam logic [2:0] RSN_REFUSED = 3'd1;
  localparam logic [2:0] RSN_TIMEOUT = 3'd2;
  localparam logic [2:0] RSN_CLOSED  = 3'd3;
  localparam logic [2:0] RSN_FULL    = 3'd4;

  localparam logic [1:0] REG_MIN_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_FORWARD     = 2'd1;
  localparam logic [1:0] REG_CLOSE_NTFY  = 2'd2;

  localparam logic [7:0] MSG_REPLY_MASK = 8'h01;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] deadline;
    logic        send_ok;
    logic        is_reply;
    logic        fwd;
    logic        notify;
    logic [15:0] id;
  } cmd_t;

  // one result
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  reason;
    logic [15:0] id;
    logic        last;
  } res_t;

endpackage

@@ hw/rtl/ort_front.sv @@
// front end: accepts requests, applies config, issues ids and deadlines
// depends on ort_pkg
`timescale 1ns / 1ps
module ort_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        action,
  input  logic [15:0]       timeout_ms,
  input  logic              send_ok,
  input  logic [7:0]        msg_type,
  input  logic [15:0]       msg_id,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [15:0]       cfg_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ort_pkg::cmd_t     cmd
);
  import ort_pkg::*;

  logic [15:0] min_tmo_r;
  logic        fwd_r, ntfy_r, closed_r;
  logic [15:0] id_r;
  logic [31:0] now_r;
  logic        cmd_valid_r;
  cmd_t        cmd_r, cmd_nxt;
  logic [15:0] tmo;
  logic        acc;

  assign full      = cmd_valid_r && !cmd_ready;
  assign acc       = push && !full;
  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;
  assign tmo       = (timeout_ms < min_tmo_r) ? min_tmo_r : timeout_ms;

  // classify the request, a tick carries the advanced clock as its deadline
  always_comb begin
    cmd_nxt          = '0;
    cmd_nxt.action   = action;
    cmd_nxt.send_ok  = send_ok;
    cmd_nxt.is_reply = |(msg_type & MSG_REPLY_MASK);
    cmd_nxt.fwd      = fwd_r;
    cmd_nxt.notify   = ntfy_r && !closed_r;
    cmd_nxt.deadline = now_r + ((action == ACT_TICK) ? 32'd1 : {16'd0, tmo});
    cmd_nxt.id       = (action == ACT_SEND) ? id_r + 16'd1 : msg_id;
  end

  // config, id counter, clock and one-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_tmo_r   <= '0;
      fwd_r       <= 1'b0;
      ntfy_r      <= 1'b0;
      closed_r    <= 1'b0;
      id_r        <= '0;
      now_r       <= '0;
      cmd_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_MIN_TIMEOUT: min_tmo_r <= cfg_data;
          REG_FORWARD:     fwd_r     <= cfg_data[0];
          REG_CLOSE_NTFY:  ntfy_r    <= cfg_data[0];
          default: ;
        endcase
      end
      cmd_valid_r <= acc || (cmd_valid_r && !cmd_ready);
      if (acc) begin
        cmd_r <= cmd_nxt;
        if (action == ACT_SEND) id_r <= id_r + 16'd1;
        if (action == ACT_TICK) now_r <= now_r + 32'd1;
        if (action == ACT_CLOSE && ntfy_r) closed_r <= 1'b1;
      end
    end
  end
endmodule

@@ hw/rtl/ort_back.sv @@
// back end: sorted pending table as a shift register, scanned one entry a cycle
// while the result slot is free; depends on ort_pkg
`timescale 1ns / 1ps
module ort_back #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  ort_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output ort_pkg::res_t res
);
  import ort_pkg::*;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01, S_SCAN = 2'b10
  } state_t;

  state_t            st_r, st_nxt;
  cmd_t              c_r;
  logic [15:0]       eid_r [DEPTH];
  logic [31:0]       edl_r [DEPTH];
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic              res_valid_r;
  res_t              res_r, res_nxt;
  logic [IW-1:0]     ix;
  logic [31:0]       diff, exp_d, exp_1;
  logic              later, hit, more, slot_free;
  logic              emit, ins_en, del_en, clr_ntfy;

  assign ix        = i_r[IW-1:0];
  assign cmd_ready = (st_r == S_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign slot_free = !res_valid_r || res_ready;
  assign diff      = edl_r[ix] - c_r.deadline;
  assign later     = (diff != 32'd0) && !diff[31];
  assign exp_d     = c_r.deadline - edl_r[0];
  assign exp_1     = c_r.deadline - edl_r[1];
  assign more      = (n_r > CW'(1)) && !exp_1[31];
  assign hit       = eid_r[ix] == c_r.id;

  // sequencer: scan positions, decide table update and result
  always_comb begin
    st_nxt   = st_r;
    i_nxt    = i_r;
    n_nxt    = n_r;
    emit     = 1'b0;
    res_nxt  = '0;
    ins_en   = 1'b0;
    del_en   = 1'b0;
    clr_ntfy = 1'b0;
    case (st_r)
      S_IDLE: begin
        i_nxt = '0;
        if (cmd_valid) st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (slot_free) begin
          case (c_r.action)
            ACT_SEND: begin
              if (!c_r.send_ok || n_r == CW'(DEPTH)) begin
                emit    = 1'b1;
                res_nxt = '{KIND_FAILED, c_r.send_ok ? RSN_FULL : RSN_REFUSED, c_r.id, 1'b1};
                st_nxt  = S_IDLE;
              end else if (i_r == n_r || later) begin
                // insert at i_r by shifting the tail up
                ins_en  = 1'b1;
                n_nxt   = n_r + CW'(1);
                emit    = 1'b1;
                res_nxt = '{KIND_SENT, RSN_NONE, c_r.id, 1'b1};
                st_nxt  = S_IDLE;
              end else i_nxt = i_r + CW'(1);
            end
            ACT_MSG: begin
              if (!c_r.is_reply) begin
                if (c_r.fwd) begin
                  emit    = 1'b1;
                  res_nxt = '{KIND_FWD, RSN_NONE, c_r.id, 1'b1};
                end
                st_nxt = S_IDLE;
              end else if (i_r == n_r) st_nxt = S_IDLE;
              else if (hit) begin
                emit    = 1'b1;
                res_nxt = '{KIND_REPLY, RSN_NONE, c_r.id, 1'b1};
                del_en  = 1'b1;
                n_nxt   = n_r - CW'(1);
                st_nxt  = S_IDLE;
              end else i_nxt = i_r + CW'(1);
            end
            ACT_TICK: begin
              // head expires; last is set when the next head does not
              if (n_r != '0 && !exp_d[31]) begin
                emit    = 1'b1;
                res_nxt = '{KIND_FAILED, RSN_TIMEOUT, eid_r[0], !more};
                del_en  = 1'b1;
                n_nxt   = n_r - CW'(1);
                st_nxt  = more ? S_SCAN : S_IDLE;
              end else st_nxt = S_IDLE;
            end
            ACT_CLOSE: begin
              if (c_r.notify) begin
                emit     = 1'b1;
                res_nxt  = '{KIND_CLOSED, RSN_NONE, 16'd0, n_r == '0};
                clr_ntfy = 1'b1;
              end else if (i_r == n_r) begin
                n_nxt  = '0;
                st_nxt = S_IDLE;
              end else begin
                emit    = 1'b1;
                res_nxt = '{KIND_FAILED, RSN_CLOSED, eid_r[ix], (i_r + CW'(1)) == n_r};
                i_nxt   = i_r + CW'(1);
              end
            end
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // state, result register and table shifts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      n_r         <= '0;
      i_r         <= '0;
      res_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      res_valid_r <= emit || (res_valid_r && !res_ready);
      if (emit) res_r <= res_nxt;
      if (st_r == S_IDLE && cmd_valid) c_r <= cmd;
      else if (clr_ntfy) c_r.notify <= 1'b0;
      if (ins_en) begin
        for (int k = 1; k < DEPTH; k++)
          if (CW'(k) > i_r && CW'(k) <= n_r) begin
            eid_r[k] <= eid_r[k-1];
            edl_r[k] <= edl_r[k-1];
          end
        eid_r[ix] <= c_r.id;
        edl_r[ix] <= c_r.deadline;
      end else if (del_en) begin
        for (int k = 0; k < DEPTH - 1; k++)
          if (CW'(k) >= i_r) begin
            eid_r[k] <= eid_r[k+1];
            edl_r[k] <= edl_r[k+1];
          end
      end
    end
  end
endmodule

@@ hw/rtl/ort_outq.sv @@
// result output register: one result waits on the result ports until popped
// depends on ort_pkg
`timescale 1ns / 1ps
module ort_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ort_pkg::res_t in_res,
  output logic          empty,
  input  logic          pop,
  output ort_pkg::res_t out_res
);
  import ort_pkg::*;
  logic out_v_r;
  res_t out_r;

  assign in_ready = !out_v_r || pop;
  assign empty    = !out_v_r;
  assign out_res  = out_r;

  // load when free or popped in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= (in_valid && in_ready) || (out_v_r && !pop);
      if (in_valid && in_ready) out_r <= in_res;
    end
  end
endmodule

@@ hw/rtl/outstanding_request_tracker_unit.sv @@
// Outstanding request tracker. Input queue port (push/full) takes one
// request per item: send, incoming message, one millisecond tick or close.
// Results leave through a queue port (empty/pop); each result carries
// kind, fail_reason, result_id and last, set on the final result of a request.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_wdata, to be
// written only while idle: the user is bound, the block does not enforce it.
// An accepted send is scanned to its insert point before its result is given,
// a matched reply likewise up to its position; an unmatched reply holds the
// back end through its scan with no result. A tick or close gives its
// results one after another, one more each cycle while results are popped.
// Only one request is worked at a time in the back end; the front end may
// take the next one meanwhile. Reset empties the table, zeroes the clock
// and id counter and clears config. When the receiver stops popping, the
// result register stays full and the back end holds its scan.
// depends on ort_pkg, ort_front, ort_back, ort_outq
`timescale 1ns / 1ps
module outstanding_request_tracker_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_timeout_ms,
  input  logic        in_send_ok,
  input  logic [7:0]  in_msg_type,
  input  logic [15:0] in_msg_id,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_fail_reason,
  output logic [15:0] out_result_id,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import ort_pkg::*;
  logic cmd_valid, cmd_ready, res_valid, res_ready;
  cmd_t cmd;
  res_t res, ores;

  assign cfg_ready = 1'b1;

  ort_front u_front (
    .clk, .rst_n, .push, .full,
    .action(in_action), .timeout_ms(in_timeout_ms), .send_ok(in_send_ok),
    .msg_type(in_msg_type), .msg_id(in_msg_id),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_wdata),
    .cmd_valid, .cmd_ready, .cmd
  );

  ort_back #(.DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .res_valid, .res_ready, .res
  );

  ort_outq u_outq (
    .clk, .rst_n, .in_valid(res_valid), .in_ready(res_ready), .in_res(res),
    .empty, .pop, .out_res(ores)
  );

  assign out_kind        = ores.kind;
  assign out_fail_reason = ores.reason;
  assign out_result_id   = ores.id;
  assign out_last        = ores.last;
endmodule

@@ hw/rtl/ort_checker.sv @@
// port-level checks for the outstanding request tracker, bound to the top
// depends on ort_pkg
`timescale 1ns / 1ps
module ort_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_kind,
  input logic [2:0]  out_fail_reason,
  input logic [15:0] out_result_id
);
  import ort_pkg::*;

  // failures always carry a reason, others never
  a_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_kind == KIND_FAILED) == (out_fail_reason != RSN_NONE)))
    else $error("reason mismatch");

  // closure notice carries no id
  a_close_id: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_CLOSED) |-> out_result_id == 16'd0)
    else $error("closure with id");

  // a waiting result holds its id while not popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_result_id)))
    else $error("request dropped");
endmodule

bind outstanding_request_tracker_unit ort_checker u_chk (
  .clk, .rst_n, .empty, .pop, .out_kind, .out_fail_reason, .out_result_id
);
